/* hw/rtl/mres_pkg.sv */
// Package for the multi-rate event scheduler: widths, register defaults, codes
// and the microprogram that sequences the shared multiplier and divider.
// No dependencies.
package mres_pkg;

    localparam int DELTA_W    = 12;
    localparam int PERIOD_W   = 14;
    localparam int LCM_W      = 16;
    localparam int ELAPSED_W  = 20;
    localparam int MUL_W      = 18;
    localparam int PROD_W     = 32;
    localparam int THR_W      = 35;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STRB_W     = 5;
    localparam int TDATA_W    = 8;

    // Restoring divider, two quotient bits per cycle.
    localparam int DIV_N_W     = ELAPSED_W;
    localparam int DIV_D_W     = LCM_W;
    localparam int DIV_ITERS   = DIV_N_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_ITERS);

    localparam logic [DELTA_W-1:0]  RST_TICK_DELTA   = DELTA_W'(40);
    localparam logic [PERIOD_W-1:0] RST_SIM_PERIOD   = PERIOD_W'(100);
    localparam logic [PERIOD_W-1:0] RST_SENSE_PERIOD = PERIOD_W'(100);
    localparam logic [PERIOD_W-1:0] RST_SEND_PERIOD  = PERIOD_W'(150);
    localparam logic [PERIOD_W-1:0] RST_COACH_PERIOD = PERIOD_W'(100);
    localparam logic [PERIOD_W-1:0] RST_THINK_OFFSET = PERIOD_W'(60);
    localparam logic [LCM_W-1:0]    RST_LCM_PERIOD   = LCM_W'(300);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_DELTA   = 3'd0,
        CFG_SIM_PERIOD   = 3'd1,
        CFG_SENSE_PERIOD = 3'd2,
        CFG_SEND_PERIOD  = 3'd3,
        CFG_COACH_PERIOD = 3'd4,
        CFG_THINK_OFFSET = 3'd5,
        CFG_LCM_PERIOD   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MUL,
        OP_CMP,
        OP_DLOAD_LIM,
        OP_DLOAD_E,
        OP_DITER,
        OP_SAVE_LIM,
        OP_UPD_INC,
        OP_UPD_QUO,
        OP_UPD_THINK,
        OP_LCM_CHK,
        OP_OUT
    } t_op;

    // Schedule selector; its value is also the strobe's bit position.
    typedef enum logic [2:0] {
        SEL_SIM    = 3'd0,
        SEL_SENSE  = 3'd1,
        SEL_VISUAL = 3'd2,
        SEL_COACH  = 3'd3,
        SEL_THINK  = 3'd4
    } t_sel;

    localparam int STEP_W = 6;

    typedef struct packed {
        t_op               op;
        t_sel              sel;
        logic [STEP_W-1:0] jmp;
    } t_uword;

    localparam logic [STEP_W-1:0] ST_IDLE   = 6'd0;
    localparam logic [STEP_W-1:0] ST_SIM    = 6'd1;
    localparam logic [STEP_W-1:0] ST_SENSE  = 6'd7;
    localparam logic [STEP_W-1:0] ST_VISUAL = 6'd15;
    localparam logic [STEP_W-1:0] ST_COACH  = 6'd23;
    localparam logic [STEP_W-1:0] ST_THINK  = 6'd31;
    localparam logic [STEP_W-1:0] ST_LCM    = 6'd34;
    localparam logic [STEP_W-1:0] ST_OUT    = 6'd35;

    function automatic t_uword mk(input t_op op, input t_sel sel,
                                  input logic [STEP_W-1:0] jmp);
        t_uword w;
        w.op  = op;
        w.sel = sel;
        w.jmp = jmp;
        return w;
    endfunction

    // Microprogram. A compare that does not fire jumps to the next schedule;
    // the division loop repeats its step until the iteration count runs out.
    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            ST_IDLE:          w = mk(OP_IDLE,      SEL_SIM,    ST_OUT);
            ST_SIM:           w = mk(OP_MUL,       SEL_SIM,    ST_IDLE);
            ST_SIM + 6'd1:    w = mk(OP_CMP,       SEL_SIM,    ST_SENSE);
            ST_SIM + 6'd2:    w = mk(OP_DLOAD_LIM, SEL_SIM,    ST_IDLE);
            ST_SIM + 6'd3:    w = mk(OP_DITER,     SEL_SIM,    ST_IDLE);
            ST_SIM + 6'd4:    w = mk(OP_SAVE_LIM,  SEL_SIM,    ST_IDLE);
            ST_SIM + 6'd5:    w = mk(OP_UPD_INC,   SEL_SIM,    ST_IDLE);
            ST_SENSE:         w = mk(OP_MUL,       SEL_SENSE,  ST_IDLE);
            ST_SENSE + 6'd1:  w = mk(OP_CMP,       SEL_SENSE,  ST_VISUAL);
            ST_SENSE + 6'd2:  w = mk(OP_DLOAD_LIM, SEL_SENSE,  ST_IDLE);
            ST_SENSE + 6'd3:  w = mk(OP_DITER,     SEL_SENSE,  ST_IDLE);
            ST_SENSE + 6'd4:  w = mk(OP_SAVE_LIM,  SEL_SENSE,  ST_IDLE);
            ST_SENSE + 6'd5:  w = mk(OP_DLOAD_E,   SEL_SENSE,  ST_IDLE);
            ST_SENSE + 6'd6:  w = mk(OP_DITER,     SEL_SENSE,  ST_IDLE);
            ST_SENSE + 6'd7:  w = mk(OP_UPD_QUO,   SEL_SENSE,  ST_IDLE);
            ST_VISUAL:        w = mk(OP_MUL,       SEL_VISUAL, ST_IDLE);
            ST_VISUAL + 6'd1: w = mk(OP_CMP,       SEL_VISUAL, ST_COACH);
            ST_VISUAL + 6'd2: w = mk(OP_DLOAD_LIM, SEL_VISUAL, ST_IDLE);
            ST_VISUAL + 6'd3: w = mk(OP_DITER,     SEL_VISUAL, ST_IDLE);
            ST_VISUAL + 6'd4: w = mk(OP_SAVE_LIM,  SEL_VISUAL, ST_IDLE);
            ST_VISUAL + 6'd5: w = mk(OP_DLOAD_E,   SEL_VISUAL, ST_IDLE);
            ST_VISUAL + 6'd6: w = mk(OP_DITER,     SEL_VISUAL, ST_IDLE);
            ST_VISUAL + 6'd7: w = mk(OP_UPD_QUO,   SEL_VISUAL, ST_IDLE);
            ST_COACH:         w = mk(OP_MUL,       SEL_COACH,  ST_IDLE);
            ST_COACH + 6'd1:  w = mk(OP_CMP,       SEL_COACH,  ST_THINK);
            ST_COACH + 6'd2:  w = mk(OP_DLOAD_LIM, SEL_COACH,  ST_IDLE);
            ST_COACH + 6'd3:  w = mk(OP_DITER,     SEL_COACH,  ST_IDLE);
            ST_COACH + 6'd4:  w = mk(OP_SAVE_LIM,  SEL_COACH,  ST_IDLE);
            ST_COACH + 6'd5:  w = mk(OP_DLOAD_E,   SEL_COACH,  ST_IDLE);
            ST_COACH + 6'd6:  w = mk(OP_DITER,     SEL_COACH,  ST_IDLE);
            ST_COACH + 6'd7:  w = mk(OP_UPD_QUO,   SEL_COACH,  ST_IDLE);
            ST_THINK:         w = mk(OP_MUL,       SEL_THINK,  ST_IDLE);
            ST_THINK + 6'd1:  w = mk(OP_CMP,       SEL_THINK,  ST_LCM);
            ST_THINK + 6'd2:  w = mk(OP_UPD_THINK, SEL_THINK,  ST_IDLE);
            ST_LCM:           w = mk(OP_LCM_CHK,   SEL_SIM,    ST_IDLE);
            ST_OUT:           w = mk(OP_OUT,       SEL_SIM,    ST_IDLE);
            default:          w = mk(OP_OUT,       SEL_SIM,    ST_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [PERIOD_W-1:0] at_least_one(input logic [PERIOD_W-1:0] v);
        return (v == '0) ? PERIOD_W'(1) : v;
    endfunction

endpackage

/* hw/rtl/multi_rate_event_scheduler.sv */
// Multi-rate event scheduler top level: microcoded sequencer over one shared
// multiplier and one shared radix-4 restoring divider. Depends on mres_pkg.
//
// Channel   Dir  Signals                              Contents
// s_axis    in   s_axis_tvalid/tready/tdata[7:0]      tick transaction
// m_axis    out  m_axis_tvalid/tready/tdata[7:0]      five strobes
// cfg       in   i_cfg_we, i_cfg_idx[2:0], i_cfg_data register write
//
// A tick without advance goes straight to the output step. With advance, each
// firing sim, sense, visual or coach schedule runs the shared divider for
// its limit, and sense, visual and coach also run it for the requotient.
// Reset is synchronous and active low; it loads the register defaults.
// A result waits in the output register while the next tick is taken; the
// sequencer holds at its last step only when that register is still full.
module multi_rate_event_scheduler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] advance, [7:1] zero
    input  logic [mres_pkg::TDATA_W-1:0]     s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] sim_strobe, [1] sense_strobe, [2] visual_strobe,
    // [3] coach_strobe, [4] think_strobe, [7:5] zero
    output logic [mres_pkg::TDATA_W-1:0]     m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [mres_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mres_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PW = mres_pkg::PERIOD_W;
    localparam int MW = mres_pkg::MUL_W;
    localparam int EW = mres_pkg::ELAPSED_W;
    localparam int NW = mres_pkg::DIV_N_W;
    localparam int DW = mres_pkg::DIV_D_W;
    localparam int TW = mres_pkg::THR_W;
    localparam int SW = mres_pkg::STEP_W;
    localparam logic [MW-1:0] MUL_ONE = MW'(1);

    // Configuration registers.
    logic [mres_pkg::DELTA_W-1:0] r_tick_delta;
    logic [PW-1:0]                r_sim_period, r_sense_period, r_send_period;
    logic [PW-1:0]                r_coach_period, r_think_offset;
    logic [mres_pkg::LCM_W-1:0]   r_lcm_period;

    // Schedule state.
    logic [EW-1:0] r_e, n_e;
    logic [MW-1:0] r_sim_mul, n_sim_mul, r_sense_mul, n_sense_mul;
    logic [MW-1:0] r_visual_mul, n_visual_mul, r_coach_mul, n_coach_mul;
    logic [MW-1:0] r_think_mul, n_think_mul;

    // Sequencer and datapath.
    logic [SW-1:0]                   r_step, n_step;
    logic [mres_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic [mres_pkg::STRB_W-1:0]     r_fire, n_fire;
    logic [MW-1:0]                   r_lim, n_lim;
    logic [NW-1:0]                   r_quo, n_quo;
    logic [DW-1:0]                   r_rem, n_rem, r_dvsr, n_dvsr;
    logic [mres_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;
    logic [mres_pkg::STRB_W-1:0]     r_out_data, n_out_data;

    mres_pkg::t_uword uw;
    logic [PW-1:0]    sim_eff, sense_eff, send_eff, coach_eff;
    logic [mres_pkg::LCM_W-1:0] lcm_eff;
    logic [mres_pkg::LCM_W+1:0] lcm_q4;
    logic [PW-1:0]    sel_period;
    logic [MW-1:0]    sel_mul;
    logic [TW-1:0]    thr;
    logic             fire;
    logic             in_acc;
    logic             out_free;
    logic [NW-1:0]    div_quo;
    logic [DW-1:0]    div_rem;

    assign uw        = mres_pkg::uc_rom(r_step);
    assign sim_eff   = mres_pkg::at_least_one(r_sim_period);
    assign sense_eff = mres_pkg::at_least_one(r_sense_period);
    assign send_eff  = mres_pkg::at_least_one(r_send_period);
    assign coach_eff = mres_pkg::at_least_one(r_coach_period);
    assign lcm_eff   = (r_lcm_period == '0) ? mres_pkg::LCM_W'(1) : r_lcm_period;
    assign lcm_q4    = {lcm_eff, 2'b00};

    assign s_axis_tready = (uw.op == mres_pkg::OP_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(mres_pkg::TDATA_W - mres_pkg::STRB_W)'(0), r_out_data};

    // Operand selection for the schedule named by the control word.
    always_comb begin
        unique case (uw.sel)
            mres_pkg::SEL_SIM: begin
                sel_period = sim_eff;
                sel_mul    = r_sim_mul;
            end
            mres_pkg::SEL_SENSE: begin
                sel_period = sense_eff;
                sel_mul    = r_sense_mul;
            end
            mres_pkg::SEL_VISUAL: begin
                sel_period = send_eff;
                sel_mul    = r_visual_mul;
            end
            mres_pkg::SEL_COACH: begin
                sel_period = coach_eff;
                sel_mul    = r_coach_mul;
            end
            mres_pkg::SEL_THINK: begin
                sel_period = sim_eff;
                sel_mul    = r_think_mul - MUL_ONE;
            end
            default: begin
                sel_period = sim_eff;
                sel_mul    = r_sim_mul;
            end
        endcase
    end

    // Due time in quarter milliseconds; the visual period is already in quarters.
    always_comb begin
        unique case (uw.sel)
            mres_pkg::SEL_VISUAL: thr = TW'(r_prod);
            mres_pkg::SEL_THINK:  thr = (TW'(r_prod) + TW'(r_think_offset)) << 2;
            default:              thr = TW'(r_prod) << 2;
        endcase
    end
    assign fire = (TW'(r_e) >= thr);

    // Two restoring division steps per cycle.
    always_comb begin
        logic [DW:0]   trial;
        logic [DW-1:0] rem_w;
        logic [NW-1:0] quo_w;
        rem_w = r_rem;
        quo_w = r_quo;
        for (int k = 0; k < 2; k++) begin
            trial = {rem_w, quo_w[NW-1]};
            quo_w = {quo_w[NW-2:0], 1'b0};
            if (trial >= {1'b0, r_dvsr}) begin
                trial    = trial - {1'b0, r_dvsr};
                quo_w[0] = 1'b1;
            end
            rem_w = trial[DW-1:0];
        end
        div_quo = quo_w;
        div_rem = rem_w;
    end

    // Sequencer: next step.
    always_comb begin
        n_step = r_step + SW'(1);
        unique case (uw.op)
            mres_pkg::OP_IDLE: begin
                if (!in_acc) begin
                    n_step = r_step;
                end else if (!s_axis_tdata[0]) begin
                    n_step = uw.jmp;
                end
            end
            mres_pkg::OP_CMP: begin
                if (!fire) begin
                    n_step = uw.jmp;
                end
            end
            mres_pkg::OP_DITER: begin
                if (r_cnt != mres_pkg::DIV_CNT_W'(mres_pkg::DIV_ITERS - 1)) begin
                    n_step = r_step;
                end
            end
            mres_pkg::OP_OUT: begin
                n_step = out_free ? uw.jmp : r_step;
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb begin
        logic [MW-1:0] quo_c;
        logic [MW-1:0] quo_next;
        quo_c        = r_quo[MW-1:0];
        quo_next     = (r_lim <= quo_c) ? MUL_ONE : quo_c + MUL_ONE;
        n_e          = r_e;
        n_sim_mul    = r_sim_mul;
        n_sense_mul  = r_sense_mul;
        n_visual_mul = r_visual_mul;
        n_coach_mul  = r_coach_mul;
        n_think_mul  = r_think_mul;
        n_prod       = r_prod;
        n_fire       = r_fire;
        n_lim        = r_lim;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_dvsr       = r_dvsr;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        unique case (uw.op)
            mres_pkg::OP_IDLE: begin
                if (in_acc) begin
                    n_fire = '0;
                    if (s_axis_tdata[0]) begin
                        n_e = r_e + EW'(r_tick_delta);
                    end
                end
            end
            mres_pkg::OP_MUL: begin
                n_prod = mres_pkg::PROD_W'(sel_period) * mres_pkg::PROD_W'(sel_mul);
            end
            mres_pkg::OP_CMP: begin
                if (fire) begin
                    n_fire[uw.sel] = 1'b1;
                end
            end
            mres_pkg::OP_DLOAD_LIM: begin
                n_quo  = NW'(lcm_eff);
                n_dvsr = DW'(sel_period);
                n_rem  = '0;
                n_cnt  = '0;
            end
            mres_pkg::OP_DLOAD_E: begin
                n_quo  = r_e;
                n_dvsr = (uw.sel == mres_pkg::SEL_VISUAL) ? DW'(send_eff)
                                                           : {sel_period, 2'b00};
                n_rem  = '0;
                n_cnt  = '0;
            end
            mres_pkg::OP_DITER: begin
                n_quo = div_quo;
                n_rem = div_rem;
                n_cnt = r_cnt + mres_pkg::DIV_CNT_W'(1);
            end
            mres_pkg::OP_SAVE_LIM: begin
                // The visual limit counts quarter periods.
                n_lim = (uw.sel == mres_pkg::SEL_VISUAL) ? {r_quo[MW-3:0], 2'b00}
                                                          : r_quo[MW-1:0];
            end
            mres_pkg::OP_UPD_INC: begin
                n_sim_mul = (r_lim <= r_sim_mul) ? MUL_ONE : r_sim_mul + MUL_ONE;
            end
            mres_pkg::OP_UPD_QUO: begin
                unique case (uw.sel)
                    mres_pkg::SEL_SENSE:  n_sense_mul  = quo_next;
                    mres_pkg::SEL_VISUAL: n_visual_mul = quo_next;
                    mres_pkg::SEL_COACH:  n_coach_mul  = quo_next;
                    default: ;
                endcase
            end
            mres_pkg::OP_UPD_THINK: begin
                n_think_mul = r_think_mul + MUL_ONE;
            end
            mres_pkg::OP_LCM_CHK: begin
                if (r_e >= EW'(lcm_q4)) begin
                    n_e         = '0;
                    n_think_mul = MUL_ONE;
                end
            end
            mres_pkg::OP_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_fire;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_delta   <= mres_pkg::RST_TICK_DELTA;
            r_sim_period   <= mres_pkg::RST_SIM_PERIOD;
            r_sense_period <= mres_pkg::RST_SENSE_PERIOD;
            r_send_period  <= mres_pkg::RST_SEND_PERIOD;
            r_coach_period <= mres_pkg::RST_COACH_PERIOD;
            r_think_offset <= mres_pkg::RST_THINK_OFFSET;
            r_lcm_period   <= mres_pkg::RST_LCM_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mres_pkg::CFG_TICK_DELTA:   r_tick_delta   <= i_cfg_data[mres_pkg::DELTA_W-1:0];
                mres_pkg::CFG_SIM_PERIOD:   r_sim_period   <= i_cfg_data[PW-1:0];
                mres_pkg::CFG_SENSE_PERIOD: r_sense_period <= i_cfg_data[PW-1:0];
                mres_pkg::CFG_SEND_PERIOD:  r_send_period  <= i_cfg_data[PW-1:0];
                mres_pkg::CFG_COACH_PERIOD: r_coach_period <= i_cfg_data[PW-1:0];
                mres_pkg::CFG_THINK_OFFSET: r_think_offset <= i_cfg_data[PW-1:0];
                mres_pkg::CFG_LCM_PERIOD:   r_lcm_period   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= mres_pkg::ST_IDLE;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_e          <= '0;
            r_sim_mul    <= MUL_ONE;
            r_sense_mul  <= MUL_ONE;
            r_visual_mul <= MUL_ONE;
            r_coach_mul  <= MUL_ONE;
            r_think_mul  <= MUL_ONE;
        end else begin
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            r_e          <= n_e;
            r_sim_mul    <= n_sim_mul;
            r_sense_mul  <= n_sense_mul;
            r_visual_mul <= n_visual_mul;
            r_coach_mul  <= n_coach_mul;
            r_think_mul  <= n_think_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_fire     <= n_fire;
        r_lim      <= n_lim;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_dvsr     <= n_dvsr;
        r_out_data <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    // After the last division step the remainder is below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == mres_pkg::OP_DITER &&
         r_cnt == mres_pkg::DIV_CNT_W'(mres_pkg::DIV_ITERS - 1))
        |=> (r_rem < r_dvsr))
        else $error("divider remainder not below divisor");

    // The restart check always leaves the time below the common period.
    a_lcm_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == mres_pkg::OP_LCM_CHK) |=> (EW'(r_e) < EW'($past(lcm_q4))))
        else $error("elapsed time not restarted at common period");

    // The fire-driven multiples never wrap to zero.
    a_mul_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_sim_mul != '0 && r_sense_mul != '0 &&
                            r_visual_mul != '0 && r_coach_mul != '0))
        else $error("schedule multiple became zero");
`endif

endmodule
